// ===== rtl/jhs_pkg.sv =====
// Shared types, constants and helper functions for the Jacobi Helmholtz stencil sweep core.
// Used by the controller, the datapath and its arithmetic units. No dependencies.
package jhs_pkg;

   localparam int TILE_WIDTH  = 256;
   localparam int TILE_HEIGHT = 256;
   localparam int PAD_W       = TILE_WIDTH + 2;
   localparam int PAD_H       = TILE_HEIGHT + 2;
   localparam int COL_W       = $clog2(PAD_W);
   localparam int ROW_W       = $clog2(PAD_H);

   localparam int DATA_W = 48;
   localparam int SUM_W  = 63;
   localparam int CSR_W  = 3;
   localparam int OPND_W = 53;
   localparam int MAG_W  = 52;
   localparam int HALF_W = 26;
   localparam int PROD_W = 105;

   localparam logic signed [63:0] MAX48_C  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN48_C  = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] ONE_Q24  = 64'sd16777216;

   typedef enum logic [2:0] {
      CSR_X_ORIGIN,
      CSR_Y_ORIGIN,
      CSR_DELTA_X,
      CSR_DELTA_Y,
      CSR_COEF_X,
      CSR_COEF_Y,
      CSR_ALPHA,
      CSR_RELAX
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_CC,
      ST_DIV_WAIT,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_GY,
      OP_CY,
      OP_GX,
      OP_CX,
      OP_T1,
      OP_T2,
      OP_P1,
      OP_P2,
      OP_P3,
      OP_R,
      OP_Q,
      OP_SQ
   } op_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_24,
      SH_46
   } shift_type;

   typedef struct packed {
      logic   accept;
      logic   rd1;
      logic   rd2;
      logic   cc_start;
      logic   mul_start;
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic row_start;
      logic interior;
      logic mul_done;
      logic div_done;
      logic out_free;
   } sts_type;

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > MAX48_C) begin
         r = MAX48_C[47:0];
      end else if (v < MIN48_C) begin
         r = MIN48_C[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   function automatic logic signed [52:0] ext53(input logic signed [47:0] v);
      return {{5{v[47]}}, v};
   endfunction

   function automatic logic signed [63:0] ext64(input logic signed [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

endpackage

// ===== rtl/jacobi_helmholtz_stencil_sweep_core.sv =====
// Top level of the Jacobi Helmholtz stencil sweep core: controller plus datapath.
// Depends on jhs_pkg, jhs_ctrl and jhs_dp.
// Items are taken one at a time. An interior item is paced by the single 26x26
// multiplier, which forms its ten rounded products one after another. The first item
// of each row that holds interior points also forms the row term, and the first item
// of a tile waits for the bit-serial reciprocal. Reset is synchronous and active high;
// no clearing pass is needed.
module jacobi_helmholtz_stencil_sweep_core import jhs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_old_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_new_value,
   output logic [SUM_W-1:0]         rsp_residual_sum,
   output logic                     rsp_sweep_done,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   // The controller sees only status flags from the datapath and answers with one
   // command word per cycle. Items stream in raster order over the padded tile; the
   // datapath keeps the raster position, so the controller never counts columns.
   cmd_type cmd;
   sts_type sts;

   jhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the two line buffers, the shared multiplier, the reciprocal
   // unit and the result register. A finished result waits in that register, so the
   // next item is taken while the consumer stalls; only a second result waits for it.
   jhs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_old_value    (req_old_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_value    (rsp_new_value),
      .rsp_residual_sum (rsp_residual_sum),
      .rsp_sweep_done   (rsp_sweep_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

// ===== rtl/jhs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for both stencil line buffers.
module jhs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 258
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/jhs_mul.sv =====
// Sequential rounding multiplier: one 26x26 partial product per cycle, then rounding and
// saturation. Depends on jhs_pkg.
module jhs_mul import jhs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [OPND_W-1:0] a,
   input  logic signed [OPND_W-1:0] b,
   input  shift_type                sh,
   input  logic                     lim63,
   output logic signed [63:0]       res,
   output logic                     done
);

   logic              busy_ff;
   logic [2:0]        cnt_ff;
   logic [MAG_W-1:0]  ma_ff, mb_ff;
   logic              neg_ff;
   shift_type         sh_ff;
   logic              lim63_ff;
   logic [PROD_W-1:0] prod_ff;
   logic signed [63:0] res_ff;
   logic              done_ff;

   logic signed [OPND_W-1:0] na, nb;
   logic [MAG_W-1:0]  ma_in, mb_in;
   logic [HALF_W-1:0] ah, bh;
   logic [MAG_W-1:0]  pp;
   logic [PROD_W-1:0] pp_sh, rnd, qv;
   logic [63:0]       lim_u;
   logic              ovf;
   logic [63:0]       res_in;

   assign na    = -a;
   assign nb    = -b;
   assign ma_in = a[OPND_W-1] ? na[MAG_W-1:0] : a[MAG_W-1:0];
   assign mb_in = b[OPND_W-1] ? nb[MAG_W-1:0] : b[MAG_W-1:0];

   assign ah = cnt_ff[1] ? ma_ff[MAG_W-1:HALF_W] : ma_ff[HALF_W-1:0];
   assign bh = cnt_ff[0] ? mb_ff[MAG_W-1:HALF_W] : mb_ff[HALF_W-1:0];
   assign pp = ah * bh;

   always_comb begin
      case (cnt_ff[1:0]) inside
         2'b00:        pp_sh = {53'd0, pp};
         2'b01, 2'b10: pp_sh = {27'd0, pp, 26'd0};
         default:      pp_sh = {1'd0, pp, 52'd0};
      endcase
   end

   always_comb begin
      case (sh_ff)
         SH_24:   begin rnd = PROD_W'(1) << 23; qv = prod_ff >> 24; end
         SH_46:   begin rnd = PROD_W'(1) << 45; qv = prod_ff >> 46; end
         default: begin rnd = '0;               qv = prod_ff;       end
      endcase
   end

   assign lim_u = lim63_ff ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_7FFF_FFFF_FFFF;
   assign ovf   = qv > {41'd0, lim_u};

   always_comb begin
      if (neg_ff) begin
         res_in = ovf ? ~lim_u : -qv[63:0];
      end else begin
         res_in = ovf ? lim_u : qv[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= '0;
            ma_ff    <= ma_in;
            mb_ff    <= mb_in;
            neg_ff   <= a[OPND_W-1] ^ b[OPND_W-1];
            sh_ff    <= sh;
            lim63_ff <= lim63;
            prod_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff < 3'd4) begin
               prod_ff <= prod_ff + pp_sh;
            end else if (cnt_ff == 3'd4) begin
               prod_ff <= prod_ff + rnd;
            end else begin
               res_ff  <= res_in;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign res  = res_ff;
   assign done = done_ff;

endmodule

// ===== rtl/jhs_div.sv =====
// Restoring reciprocal unit: 1/cc in signed Q1.46 from cc in Q23.24, one quotient bit
// per cycle. Depends on jhs_pkg.
module jhs_div import jhs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] cc,
   output logic signed [DATA_W-1:0] recip,
   output logic                     done
);

   localparam logic [6:0]  LastStep = 7'd70;
   localparam logic [47:0] SmallMag = 48'd8388608;

   logic        busy_ff, fin_ff, done_ff, neg_ff;
   logic [6:0]  cnt_ff;
   logic [47:0] m_ff, rem_ff, q_ff;
   logic signed [DATA_W-1:0] recip_ff;

   logic [47:0] ncc, mag;
   logic [48:0] rem_sh, rem_sub;
   logic        ge;
   logic [48:0] q_rnd;
   logic [47:0] q_sat;

   assign ncc     = -cc;
   assign mag     = cc[DATA_W-1] ? ncc : cc;
   assign rem_sh  = {rem_ff, (cnt_ff == LastStep)};
   assign ge      = rem_sh >= {1'b0, m_ff};
   assign rem_sub = rem_sh - {1'b0, m_ff};
   assign q_rnd   = {1'b0, q_ff} + 49'(({rem_ff, 1'b0} >= {1'b0, m_ff}));
   assign q_sat   = (q_rnd > 49'(MAX48_C[47:0])) ? MAX48_C[47:0] : q_rnd[47:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            neg_ff <= cc[DATA_W-1];
            m_ff   <= mag;
            rem_ff <= '0;
            q_ff   <= '0;
            cnt_ff <= LastStep;
            if (cc == '0) begin
               recip_ff <= MAX48_C[47:0];
               done_ff  <= 1'b1;
            end else if (mag <= SmallMag) begin
               recip_ff <= cc[DATA_W-1] ? MIN48_C[47:0] : MAX48_C[47:0];
               done_ff  <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sub[47:0] : rem_sh[47:0];
            q_ff   <= {q_ff[46:0], ge};
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            recip_ff <= neg_ff ? -q_sat : q_sat;
            fin_ff   <= 1'b0;
            done_ff  <= 1'b1;
         end
      end
   end

   assign recip = recip_ff;
   assign done  = done_ff;

endmodule

// ===== rtl/jhs_ctrl.sv =====
// Sequencing state machine: accepts items, orders line buffer access, the reciprocal
// and the chain of rounded products. Depends on jhs_pkg.
module jhs_ctrl import jhs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in, op_next;

   always_comb begin
      case (op_ff)
         OP_GY:   op_next = OP_CY;
         OP_GX:   op_next = OP_CX;
         OP_CX:   op_next = OP_T1;
         OP_T1:   op_next = OP_T2;
         OP_T2:   op_next = OP_P1;
         OP_P1:   op_next = OP_P2;
         OP_P2:   op_next = OP_P3;
         OP_P3:   op_next = OP_R;
         OP_R:    op_next = OP_Q;
         OP_Q:    op_next = OP_SQ;
         default: op_next = op_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RD1;
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: begin
            if (sts.first) begin
               state_in = ST_CC;
            end else if (sts.row_start) begin
               state_in = ST_MUL_ISSUE;
               op_in    = OP_GY;
            end else if (sts.interior) begin
               state_in = ST_MUL_ISSUE;
               op_in    = OP_GX;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CC: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done) state_in = ST_IDLE;
         end
         ST_MUL_ISSUE: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (sts.mul_done) begin
               if (op_ff == OP_CY) begin
                  state_in = ST_IDLE;
               end else if (op_ff == OP_SQ) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL_ISSUE;
                  op_in    = op_next;
               end
            end
         end
         ST_OUT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.rd1       = (state_ff == ST_RD1);
      cmd.rd2       = (state_ff == ST_RD2);
      cmd.cc_start  = (state_ff == ST_CC);
      cmd.mul_start = (state_ff == ST_MUL_ISSUE);
      cmd.op        = op_ff;
      cmd.out_load  = (state_ff == ST_OUT) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_GY;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) cmd.accept |=> state_ff == ST_RD1)
      else $error("accepted item did not start the line buffer read");
   assert property (@(posedge clock) disable iff (reset)
      sts.mul_done |-> state_ff == ST_MUL_WAIT)
      else $error("product finished while the sequencer was not waiting for it");
   assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == ST_DIV_WAIT)
      else $error("reciprocal finished while the sequencer was not waiting for it");
`endif

endmodule

// ===== rtl/jhs_dp.sv =====
// Datapath: configuration registers, position counters, line buffers, the shared
// multiplier and reciprocal units, and the result register. Depends on jhs_pkg,
// jhs_ram, jhs_mul and jhs_div.
module jhs_dp import jhs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic signed [DATA_W-1:0] req_old_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_new_value,
   output logic [SUM_W-1:0]         rsp_residual_sum,
   output logic                     rsp_sweep_done,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   // Configuration registers.
   logic [15:0]              x_origin_ff, y_origin_ff;
   logic [25:0]              delta_x_ff, delta_y_ff, relax_ff;
   logic [46:0]              coef_x_ff, coef_y_ff;
   logic signed [DATA_W-1:0] alpha_ff;

   // Position and per-item registers.
   logic [COL_W-1:0]         col_cnt_ff, col_ff;
   logic [ROW_W-1:0]         row_cnt_ff, row_ff;
   logic signed [DATA_W-1:0] s_ff, nv_ff, cv_ff, west_ff, east_ff;

   // Sweep and row state.
   logic signed [DATA_W-1:0] cc_ff, recip_ff, fy_ff;
   logic [SUM_W-1:0]         acc_ff;

   // Working registers of the update chain.
   logic signed [OPND_W-1:0] shp_c_ff, num_ff;
   logic signed [DATA_W-1:0] fx_ff, t_ff, rhs_ff, r_ff, nu_ff;

   logic                     rsp_valid_ff, rsp_sweep_done_ff;
   logic signed [DATA_W-1:0] rsp_new_value_ff;
   logic [SUM_W-1:0]         rsp_residual_sum_ff;

   logic [DATA_W-1:0]  u_rdata, m_rdata;
   logic               m_re;
   logic [COL_W-1:0]   m_raddr;
   logic               last_col;

   logic signed [50:0]       cc_wide;
   logic signed [DATA_W-1:0] cc_new, recip_w;
   logic                     div_done_w, mul_done_w;

   logic signed [OPND_W-1:0] opa, opb;
   shift_type                opsh;
   logic                     oplim63;
   logic signed [63:0]       mres;
   logic [16:0]              gx, gy;
   logic signed [63:0]       rhs_wide;
   logic [63:0]              acc_sum;
   logic                     done_pt;

   assign csr_ready = 1'b1;
   assign last_col  = (col_ff == COL_W'(PAD_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= '0;
         y_origin_ff <= '0;
         delta_x_ff  <= 26'd131072;
         delta_y_ff  <= 26'd131072;
         coef_x_ff   <= 47'd16777216;
         coef_y_ff   <= 47'd16777216;
         alpha_ff    <= 48'sd13421773;
         relax_ff    <= 26'd16777216;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            CSR_X_ORIGIN: x_origin_ff <= csr_data[15:0];
            CSR_Y_ORIGIN: y_origin_ff <= csr_data[15:0];
            CSR_DELTA_X:  delta_x_ff  <= csr_data[25:0];
            CSR_DELTA_Y:  delta_y_ff  <= csr_data[25:0];
            CSR_COEF_X:   coef_x_ff   <= csr_data[46:0];
            CSR_COEF_Y:   coef_y_ff   <= csr_data[46:0];
            CSR_ALPHA:    alpha_ff    <= csr_data;
            CSR_RELAX:    relax_ff    <= csr_data[25:0];
            default:      ;
         endcase
      end
   end

   // Raster position of the next item and of the item in work.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (cmd.accept) begin
         if (col_cnt_ff == COL_W'(PAD_W - 1)) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= (row_cnt_ff == ROW_W'(PAD_H - 1)) ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_ff <= col_cnt_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff <= col_cnt_ff;
         row_ff <= row_cnt_ff;
         s_ff   <= req_old_value;
      end
      if (cmd.rd1) begin
         nv_ff   <= u_rdata;
         cv_ff   <= m_rdata;
         west_ff <= cv_ff;
      end
      if (cmd.rd2) begin
         east_ff <= m_rdata;
      end
   end

   assign m_re    = cmd.accept || (cmd.rd1 && !last_col);
   assign m_raddr = cmd.accept ? col_cnt_ff : col_ff + COL_W'(1);

   jhs_ram #(.WIDTH(DATA_W), .DEPTH(PAD_W)) u_upper_line (
      .clock (clock),
      .we    (cmd.rd2),
      .waddr (col_ff),
      .wdata (cv_ff),
      .re    (cmd.accept),
      .raddr (col_cnt_ff),
      .rdata (u_rdata)
   );

   jhs_ram #(.WIDTH(DATA_W), .DEPTH(PAD_W)) u_middle_line (
      .clock (clock),
      .we    (cmd.rd2),
      .waddr (col_ff),
      .wdata (s_ff),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   // Center coefficient and its reciprocal, once per sweep.
   assign cc_wide = -($signed({4'd0, coef_x_ff}) <<< 1) - ($signed({4'd0, coef_y_ff}) <<< 1)
                    - $signed({{3{alpha_ff[47]}}, alpha_ff});
   assign cc_new  = sat48(64'(cc_wide));

   jhs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.cc_start),
      .cc    (cc_new),
      .recip (recip_w),
      .done  (div_done_w)
   );

   // Operand selection for the shared multiplier.
   assign gx = 17'(x_origin_ff) + 17'(col_ff) - 17'd1;
   assign gy = 17'(y_origin_ff) + 17'(row_ff) - 17'd2;

   always_comb begin
      opsh    = SH_24;
      oplim63 = 1'b0;
      case (cmd.op)
         OP_GX: begin
            opa = {36'd0, gx}; opb = {27'd0, delta_x_ff}; opsh = SH_0; oplim63 = 1'b1;
         end
         OP_GY: begin
            opa = {36'd0, gy}; opb = {27'd0, delta_y_ff}; opsh = SH_0; oplim63 = 1'b1;
         end
         OP_CX, OP_CY: begin opa = shp_c_ff; opb = shp_c_ff; end
         OP_T1: begin opa = -ext53(alpha_ff); opb = ext53(fx_ff); end
         OP_T2: begin opa = ext53(t_ff); opb = ext53(fy_ff); end
         OP_P1: begin opa = {6'd0, coef_x_ff}; opb = ext53(west_ff) + ext53(east_ff); end
         OP_P2: begin opa = {6'd0, coef_y_ff}; opb = ext53(nv_ff) + ext53(s_ff); end
         OP_P3: begin opa = ext53(cc_ff); opb = ext53(cv_ff); end
         OP_R:  begin opa = num_ff; opb = ext53(recip_ff); opsh = SH_46; end
         OP_Q:  begin opa = {27'd0, relax_ff}; opb = ext53(r_ff); end
         OP_SQ: begin opa = ext53(r_ff); opb = ext53(r_ff); oplim63 = 1'b1; end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   jhs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (opa),
      .b     (opb),
      .sh    (opsh),
      .lim63 (oplim63),
      .res   (mres),
      .done  (mul_done_w)
   );

   // The second source product arrives on mres and is combined with both shape terms.
   assign rhs_wide = mres - (ext64(fx_ff) <<< 1) - (ext64(fy_ff) <<< 1);
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, mres[62:0]};

   // Sweep state: center coefficient, reciprocal, row term and residual sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff    <= '0;
         recip_ff <= '0;
         fy_ff    <= '0;
         acc_ff   <= '0;
      end else begin
         if (cmd.cc_start) begin
            cc_ff  <= cc_new;
            acc_ff <= '0;
         end
         if (div_done_w) begin
            recip_ff <= recip_w;
         end
         if (mul_done_w && cmd.op == OP_CY) begin
            fy_ff <= sat48(ONE_Q24 - mres);
         end
         if (mul_done_w && cmd.op == OP_SQ) begin
            acc_ff <= acc_sum[63] ? {SUM_W{1'b1}} : acc_sum[62:0];
         end
      end
   end

   // Write-back of each finished product.
   always_ff @(posedge clock) begin
      if (mul_done_w) begin
         case (cmd.op)
            OP_GX, OP_GY: shp_c_ff <= $signed(mres[52:0]) - $signed(ONE_Q24[52:0]);
            OP_CX: fx_ff  <= sat48(ONE_Q24 - mres);
            OP_T1: t_ff   <= mres[47:0];
            OP_T2: rhs_ff <= sat48(rhs_wide);
            OP_P1: num_ff <= $signed(mres[52:0]);
            OP_P2: num_ff <= num_ff + $signed(mres[52:0]);
            OP_P3: num_ff <= num_ff + $signed(mres[52:0]) - ext53(rhs_ff);
            OP_R:  r_ff   <= mres[47:0];
            OP_Q:  nu_ff  <= sat48(ext64(cv_ff) - mres);
            default: ;
         endcase
      end
   end

   // Result register.
   assign done_pt = (row_ff == ROW_W'(PAD_H - 1)) && (col_ff == COL_W'(TILE_WIDTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_new_value_ff    <= nu_ff;
         rsp_residual_sum_ff <= done_pt ? acc_ff : '0;
         rsp_sweep_done_ff   <= done_pt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_value    = rsp_new_value_ff;
   assign rsp_residual_sum = rsp_residual_sum_ff;
   assign rsp_sweep_done   = rsp_sweep_done_ff;

   always_comb begin
      sts.first     = (col_ff == '0) && (row_ff == '0);
      sts.row_start = (col_ff == '0) && (row_ff >= ROW_W'(2));
      sts.interior  = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(1))
                      && (col_ff <= COL_W'(TILE_WIDTH));
      sts.mul_done  = mul_done_w;
      sts.div_done  = div_done_w;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while its item was still held");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sweep_done_ff) |-> rsp_residual_sum_ff == '0)
      else $error("residual sum shown on an item that does not end the sweep");
`endif

endmodule

// ===== test/jacobi_helmholtz_stencil_sweep_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Jacobi Helmholtz stencil sweep core.
// Depends on jhs_pkg and jacobi_helmholtz_stencil_sweep_core; needs nothing else.
module jacobi_helmholtz_stencil_sweep_core_test;
   import jhs_pkg::*;

   localparam int RANDOM_ITEMS = 1875;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int LONG_HOLD    = 3000;

   // One updated interior point as the block should report it.
   typedef struct {
      logic signed [DATA_W-1:0] new_value;
      logic [SUM_W-1:0]         residual_sum;
      logic                     sweep_done;
   } point_type;

   // Holds its own copy of the registers and the sweep state, predicts the result of
   // every accepted interior item and compares each result with the oldest prediction.
   class stencil_sweep_scoreboard;
      logic [15:0]        x_origin, y_origin;
      logic [25:0]        delta_x, delta_y, relax_factor;
      logic [46:0]        coef_x, coef_y;
      logic signed [47:0] alpha_gain;
      logic signed [63:0] upper_row[PAD_W];
      logic signed [63:0] middle_row[PAD_W];
      int                 col, row;
      logic [63:0]        residual_total;
      logic signed [63:0] center_coef, center_recip, row_shape;
      point_type          expected_points[$];
      int                 mismatches;
      int                 checked;

      function new();
         x_origin = 0; y_origin = 0;
         delta_x = 131072; delta_y = 131072;
         coef_x = 16777216; coef_y = 16777216;
         alpha_gain = 13421773;
         relax_factor = 16777216;
         foreach (upper_row[i]) begin
            upper_row[i] = 0;
            middle_row[i] = 0;
         end
         col = 0; row = 0;
         residual_total = 0;
         center_coef = 0; center_recip = 0; row_shape = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_reg(csr_reg_type idx, logic [47:0] data);
         case (idx)
            CSR_X_ORIGIN: x_origin = data[15:0];
            CSR_Y_ORIGIN: y_origin = data[15:0];
            CSR_DELTA_X:  delta_x = data[25:0];
            CSR_DELTA_Y:  delta_y = data[25:0];
            CSR_COEF_X:   coef_x = data[46:0];
            CSR_COEF_Y:   coef_y = data[46:0];
            CSR_ALPHA:    alpha_gain = data;
            CSR_RELAX:    relax_factor = data[25:0];
            default: ;
         endcase
      endfunction

      function logic signed [63:0] clamp48(logic signed [63:0] v);
         if (v > MAX48_C) return MAX48_C;
         if (v < MIN48_C) return MIN48_C;
         return v;
      endfunction

      // Exact product, rounded to nearest with ties away from zero, then clamped.
      function logic signed [63:0] mul_round(logic signed [63:0] a, logic signed [63:0] b,
                                             int sh, logic [63:0] lim);
         logic signed [127:0] wa, wb, p;
         logic [127:0]        m, q;
         logic                neg;
         wa = a;
         wb = b;
         p = wa * wb;
         neg = p < 0;
         m = neg ? -p : p;
         q = (m + (128'd1 << (sh - 1))) >> sh;
         if (q > {64'd0, lim}) return neg ? -$signed(lim) - 1 : $signed(lim);
         return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
      endfunction

      // Reciprocal of a Q23.24 value in Q1.46; tiny magnitudes clamp with their sign.
      function logic signed [63:0] reciprocal(logic signed [63:0] c);
         logic [127:0] m, q, rem;
         if (c == 0) return MAX48_C;
         m = c < 0 ? -c : c;
         if (m <= (128'd1 << 23)) return c > 0 ? MAX48_C : MIN48_C;
         q = (128'd1 << 70) / m;
         rem = (128'd1 << 70) % m;
         if (rem * 2 >= m) q = q + 1;
         if (q > MAX48_C) q = MAX48_C;
         return c > 0 ? $signed(q[63:0]) : -$signed(q[63:0]);
      endfunction

      // 1 - (g*d - 1)^2 in Q23.24.
      function logic signed [63:0] shape(logic [63:0] g, logic [63:0] d);
         logic signed [63:0] c;
         c = $signed(g * d) - ONE_Q24;
         return clamp48(ONE_Q24 - mul_round(c, c, 24, MAX48_C));
      endfunction

      function void note_old_value(logic signed [47:0] value);
         logic signed [63:0] s, n, cv, w, e, fx, t, rhs, num, r, sq;
         point_type          pt;
         s = value;
         if (col == 0 && row == 0) begin
            center_coef = clamp48(-2 * $signed({17'd0, coef_x}) - 2 * $signed({17'd0, coef_y})
                                  - alpha_gain);
            center_recip = reciprocal(center_coef);
            residual_total = 0;
         end
         if (col == 0 && row >= 2) row_shape = shape(y_origin + row - 2, delta_y);
         n = upper_row[col];
         cv = middle_row[col];
         upper_row[col] = cv;
         middle_row[col] = s;
         if (row >= 2 && col >= 1 && col <= TILE_WIDTH) begin
            w = upper_row[col - 1];
            e = middle_row[col + 1];
            fx = shape(x_origin + col - 1, delta_x);
            t = mul_round(-$signed({{16{alpha_gain[47]}}, alpha_gain}), fx, 24, MAX48_C);
            t = mul_round(t, row_shape, 24, MAX48_C);
            rhs = clamp48(t - 2 * fx - 2 * row_shape);
            num = mul_round($signed({17'd0, coef_x}), w + e, 24, MAX48_C)
                + mul_round($signed({17'd0, coef_y}), n + s, 24, MAX48_C)
                + mul_round(center_coef, cv, 24, MAX48_C) - rhs;
            r = mul_round(num, center_recip, 46, MAX48_C);
            sq = mul_round(r, r, 24, 64'h7FFF_FFFF_FFFF_FFFF);
            residual_total = residual_total + sq;
            if (residual_total > 64'h7FFF_FFFF_FFFF_FFFF)
               residual_total = 64'h7FFF_FFFF_FFFF_FFFF;
            pt.new_value = 48'(clamp48(cv - mul_round($signed({38'd0, relax_factor}), r, 24,
                                                      MAX48_C)));
            pt.sweep_done = (row == PAD_H - 1) && (col == TILE_WIDTH);
            pt.residual_sum = pt.sweep_done ? residual_total[62:0] : '0;
            expected_points.push_back(pt);
         end
         col++;
         if (col >= PAD_W) begin
            col = 0;
            row++;
            if (row >= PAD_H) row = 0;
         end
      endfunction

      function void check_point(logic signed [47:0] nv, logic [62:0] rs, logic done);
         point_type pt;
         checked++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: new_value %0d", nv);
            return;
         end
         pt = expected_points.pop_front();
         if (pt.new_value !== nv || pt.residual_sum !== rs || pt.sweep_done !== done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch at result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        checked, pt.new_value, pt.residual_sum, pt.sweep_done,
                        nv, rs, done);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_old_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_new_value;
   logic [SUM_W-1:0]         rsp_residual_sum;
   logic                     rsp_sweep_done;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_W-1:0]         csr_index;
   logic [DATA_W-1:0]        csr_data;

   stencil_sweep_scoreboard sweep_sb = new();
   int  cycle_count = 0;
   int  items_sent = 0;
   int  csr_writes = 0;
   logic long_hold_request;

   jacobi_helmholtz_stencil_sweep_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_old_value    (req_old_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_value    (rsp_new_value),
      .rsp_residual_sum (rsp_residual_sum),
      .rsp_sweep_done   (rsp_sweep_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // The clock starts low so the first rising edge comes after time zero.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  sweep_sb.expected_points.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side. The receiver alternates runs of acceptance with stalls of random
   // length, mostly short and sometimes long, and serves one long hold on request
   // while the sender keeps pushing, so the result register fills and the sender stalls.
   int  stall_left = 0;
   int  free_left = 0;
   logic long_hold_taken = 1'b0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sweep_sb.check_point(rsp_new_value, rsp_residual_sum, rsp_sweep_done);
      if (long_hold_request && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(0, 40);
         stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(0, 4);
      end
   end

   // Old values lean toward moderate magnitudes so the stencil stays out of
   // saturation most of the time, with full-range and extreme values mixed in.
   function automatic logic signed [47:0] random_old_value();
      logic signed [47:0] v;
      case ($urandom_range(0, 9))
         0:       v = 48'({$urandom(), $urandom()});
         1:       v = ($urandom_range(0, 1) != 0) ? MAX48_C[47:0] : MIN48_C[47:0];
         2, 3:    v = $signed(48'($urandom_range(0, 1 << 30))) - (48'sd1 <<< 29);
         default: v = {{16{1'b0}}, $urandom()} - 48'sh0000_8000_0000;
      endcase
      return v;
   endfunction

   task automatic send_old_value(input logic signed [47:0] value, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_old_value <= value;
      do @(posedge clock); while (req_stall);
      sweep_sb.note_old_value(value);
      items_sent++;
   endtask

   // Leaves the write channel valid; the caller drops it after its last write.
   task automatic write_csr(input csr_reg_type idx, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sweep_sb.write_reg(idx, data);
      csr_writes++;
   endtask

   // Registers may only change while the block is idle: every expected result has
   // come back and the halo items that produce nothing have had time to drain.
   task automatic wait_until_idle();
      while (sweep_sb.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Settings per phase: phase one pins origins, coefficients and alpha to their
   // largest, phase two all to smallest, the rest random, some with stray upper bits.
   task automatic program_phase(input int phase);
      logic [47:0] v[8];
      case (phase)
         1: begin
            v[0] = 16'hFFFF; v[1] = 16'hFFFF;
            v[2] = 48'd33554432; v[3] = 48'd33554432;
            v[4] = 48'h7FFF_FFFF_FFFF; v[5] = 48'h7FFF_FFFF_FFFF;
            v[6] = MAX48_C[47:0]; v[7] = 48'd33554432;
         end
         2: begin
            v[0] = 0; v[1] = 0; v[2] = 0; v[3] = 0; v[4] = 0; v[5] = 0;
            v[6] = MIN48_C[47:0]; v[7] = 0;
         end
         default: begin
            v[0] = 48'({$urandom(), $urandom()});
            v[1] = 48'({$urandom(), $urandom()});
            v[2] = $urandom_range(0, 1 << 20) | (48'($urandom()) << 26);
            v[3] = $urandom_range(0, 1 << 20) | (48'($urandom()) << 26);
            v[4] = $urandom_range(0, 1 << 28) | (48'($urandom_range(0, 1)) << 47);
            v[5] = $urandom_range(0, 1 << 28);
            v[6] = $signed(48'($urandom_range(0, 1 << 28))) - (48'sd1 <<< 27);
            v[7] = $urandom_range(0, 33554432);
         end
      endcase
      for (int i = 0; i < 8; i++) write_csr(csr_reg_type'(i), v[i]);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [47:0] directed[$];
      int                 per_phase;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_old_value <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_X_ORIGIN;
      csr_data <= '0;
      long_hold_request <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The center coefficient is latched at the first item of the tile, so the
      // opening settings are ordinary ones that keep it well away from zero.
      write_csr(CSR_X_ORIGIN, 48'd3);
      write_csr(CSR_Y_ORIGIN, 48'd5);
      write_csr(CSR_DELTA_X, 48'd131072);
      write_csr(CSR_DELTA_Y, 48'd262144);
      write_csr(CSR_COEF_X, 48'd16777216);
      write_csr(CSR_COEF_Y, 48'd33554432);
      write_csr(CSR_ALPHA, 48'd13421773);
      write_csr(CSR_RELAX, 48'd25165824);
      csr_valid <= 1'b0;

      // Directed items: extremes and sign boundaries of the old value, back to back.
      directed = '{MAX48_C[47:0], MIN48_C[47:0], 48'sd0, -48'sd1, 48'sd1,
                   48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 48'sd16777216,
                   -48'sd16777216, 48'sh7FFF_FFFF_FFFE, 48'sh8000_0000_0001};
      while (directed.size() < 25) directed.push_back(random_old_value());
      foreach (directed[i]) send_old_value(directed[i], 0);

      // Random part in phases. The tile is filled row by row, so every phase
      // continues the same sweep under new register settings.
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            req_valid <= 1'b0;
            wait_until_idle();
            program_phase(p);
         end
         if (p == 3) long_hold_request <= 1'b1;
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 3) != 0 || p == 3) begin
               send_old_value(random_old_value(), 0);
            end else begin
               send_old_value(random_old_value(), ($urandom_range(0, 9) == 0)
                              ? $urandom_range(20, 120) : $urandom_range(1, 3));
            end
         end
      end
      req_valid <= 1'b0;

      while (sweep_sb.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d old values over %0d register phases with %0d register writes,",
               items_sent, PHASES, csr_writes);
      $display("checked %0d stencil results, %0d mismatches", sweep_sb.checked,
               sweep_sb.mismatches);
      if (sweep_sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== jacobi_helmholtz_stencil_sweep_core.f =====
rtl/jhs_pkg.sv
rtl/jhs_ram.sv
rtl/jhs_mul.sv
rtl/jhs_div.sv
rtl/jhs_ctrl.sv
rtl/jhs_dp.sv
rtl/jacobi_helmholtz_stencil_sweep_core.sv
test/jacobi_helmholtz_stencil_sweep_core_test.sv
